### design/xfsd_pkg.sv
// Shared types, constants and helper functions for the XOR float32 stream decoder.
// Used by the controller, the datapath and the top level; depends on nothing else.
package xfsd_pkg;

    localparam int BYTE_BITS     = 8;
    localparam int WORD_BITS     = 32;
    localparam int ENTRY_BITS    = 5;
    localparam int COUNT_BITS    = 4;
    localparam int IDX_BITS      = 3;
    localparam int TABLE_ENTRIES = 16;

    localparam logic [WORD_BITS-1:0] END_MARKER = 32'h7fc0_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // take a new byte from the input channel
        logic step;   // parse the next compressed bit
        logic flush;  // close the byte: release the held result as last of run
    } xfsd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic room;        // a new result can be produced without loss
        logic parse_done;  // end marker seen, remaining bits are ignored
    } xfsd_status_t;

    // Bits needed to index a table of n entries (n from 1 to 16).
    function automatic logic [IDX_BITS-1:0] index_width(input logic [COUNT_BITS:0] n);
        logic [IDX_BITS-1:0] w;
        if (n <= 5'd1) begin
            w = 3'd0;
        end else if (n <= 5'd2) begin
            w = 3'd1;
        end else if (n <= 5'd4) begin
            w = 3'd2;
        end else if (n <= 5'd8) begin
            w = 3'd3;
        end else begin
            w = 3'd4;
        end
        return w;
    endfunction

    // Number of centre bits for a window; zero once the window covers the word.
    function automatic logic [5:0] centre_width(input logic [ENTRY_BITS-1:0] lead,
                                                input logic [ENTRY_BITS-1:0] trail);
        logic [5:0] sum;
        sum = {1'b0, lead} + {1'b0, trail};
        return (sum >= 6'd32) ? 6'd0 : 6'd32 - sum;
    endfunction

endpackage

### design/xor_float32_stream_decoder.sv
// Top level of the XOR float32 stream decoder: joins the bit sequencing
// controller (xfsd_ctrl) and the parsing datapath (xfsd_dp); uses xfsd_pkg.
//
//  Channel  Dir  Handshake            Payload
//  s_       in   s_tvalid / s_tready  s_tdata = data_byte, s_tuser = block_start
//  m_       out  m_tvalid / m_tready  m_tdata = float_bits, m_tuser = block_end,
//                                     m_tlast = last_of_run
//
// Each accepted byte is parsed one compressed bit per clock while the parser is
// not halted, most significant bit first; after its eight bits comes a closing
// cycle in which the next byte can already be accepted.
// The closing cycle marks the last result of the byte; results are held in a
// one-entry hold register ahead of the output register.
// Once the end marker is decoded the remaining bits are skipped, so such a byte
// closes early. The parser halts on any bit, and the closing cycle waits, only
// while the output register still holds an untaken word and another result is
// already waiting in the hold register.
// Reset is synchronous and active low; it clears both tables, the index
// widths, the window and the previous value, and puts the parser at the header.
module xor_float32_stream_decoder #(
    parameter int TABLE_ENTRIES = xfsd_pkg::TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] block_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] float_bits
    output logic        m_tuser,   // [0] block_end
    output logic        m_tlast
);

    // The controller only knows about bit timing; all decoding state sits in
    // the datapath, which reports whether a result can be taken and whether
    // the block has ended.
    xfsd_pkg::xfsd_cmd_t    cmd;
    xfsd_pkg::xfsd_status_t status;

    xfsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    xfsd_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### design/xfsd_ctrl.sv
// Controller of the XOR float32 stream decoder: sequences the bits of each byte.
// Depends on xfsd_pkg for the command and status types.
module xfsd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  xfsd_pkg::xfsd_status_t status,
    output xfsd_pkg::xfsd_cmd_t  cmd
);

    localparam int CNT_W = $clog2(xfsd_pkg::BYTE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_BITS  = 3'b010,
        ST_FLUSH = 3'b100
    } ctrl_state_t;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] bits_left_reg, bits_left_next;
    logic             accept;

    always_comb begin
        state_next     = state_reg;
        bits_left_next = bits_left_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_BITS: begin
                if (status.parse_done) begin
                    state_next = ST_FLUSH;
                end else if (status.room) begin
                    cmd.step = 1'b1;
                    if (bits_left_reg == '0) begin
                        state_next = ST_FLUSH;
                    end else begin
                        bits_left_next = bits_left_reg - 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (status.room) begin
                    cmd.flush  = 1'b1;
                    s_tready   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        accept   = s_tvalid && s_tready;
        cmd.load = accept;
        if (accept) begin
            state_next     = ST_BITS;
            bits_left_next = CNT_W'(xfsd_pkg::BYTE_BITS - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bits_left_reg <= '0;
        end else begin
            state_reg     <= state_next;
            bits_left_reg <= bits_left_next;
        end
    end

    a_step_only_in_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> state_reg == ST_BITS && status.room)
        else $error("bit step issued outside the bit phase or without room");

    a_load_starts_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_BITS
                     && bits_left_reg == CNT_W'(xfsd_pkg::BYTE_BITS - 1))
        else $error("accepted word did not start a full bit sequence");

    a_no_step_with_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.step && (cmd.flush || cmd.load)))
        else $error("bit step overlaps a flush or a load");

endmodule

### design/xfsd_dp.sv
// Datapath of the XOR float32 stream decoder: bit parser, tables, value state
// and the result hold and output registers. Depends on xfsd_pkg.
module xfsd_dp #(
    parameter int TABLE_ENTRIES = xfsd_pkg::TABLE_ENTRIES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  xfsd_pkg::xfsd_cmd_t    cmd,
    output xfsd_pkg::xfsd_status_t status,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int EB     = xfsd_pkg::ENTRY_BITS;
    localparam int CB     = xfsd_pkg::COUNT_BITS;
    localparam int IB     = xfsd_pkg::IDX_BITS;
    localparam int WB     = xfsd_pkg::WORD_BITS;
    localparam int TIDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [10:0] {
        PH_EQ     = 11'b000_0000_0001,
        PH_UPD    = 11'b000_0000_0010,
        PH_LCNT   = 11'b000_0000_0100,
        PH_LENT   = 11'b000_0000_1000,
        PH_TCNT   = 11'b000_0001_0000,
        PH_TENT   = 11'b000_0010_0000,
        PH_CTRL1  = 11'b000_0100_0000,
        PH_CTRL2  = 11'b000_1000_0000,
        PH_IDX    = 11'b001_0000_0000,
        PH_CENTRE = 11'b010_0000_0000,
        PH_DONE   = 11'b100_0000_0000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [EB-1:0]   lt_reg [TABLE_ENTRIES];
    logic [EB-1:0]   lt_next [TABLE_ENTRIES];
    logic [EB-1:0]   tt_reg [TABLE_ENTRIES];
    logic [EB-1:0]   tt_next [TABLE_ENTRIES];
    logic [IB-1:0]   lib_reg, lib_next, tib_reg, tib_next;
    logic            eq_reg, eq_next;
    logic [WB-1:0]   prev_reg, prev_next;
    logic [EB-1:0]   wl_reg, wl_next, wt_reg, wt_next;
    logic [WB-1:0]   fs_reg, fs_next;
    logic [5:0]      fc_reg, fc_next;
    logic [CB:0]     tpos_reg, tpos_next, tlen_reg, tlen_next;
    logic [7:0]      byte_reg, byte_next;

    logic            pend_valid_reg, pend_valid_next;
    logic [WB-1:0]   pend_bits_reg, pend_bits_next;
    logic            pend_end_reg, pend_end_next;
    logic            out_valid_reg, out_valid_next;
    logic [WB-1:0]   out_bits_reg, out_bits_next;
    logic            out_end_reg, out_end_next;
    logic            out_last_reg, out_last_next;

    logic            b;
    logic [WB-1:0]   fs_sh;
    logic [5:0]      fc_inc;
    logic [3:0]      idx_sum;
    logic [7:0]      idx_src;
    logic [3:0]      lead_idx, trail_idx;
    logic [EB-1:0]   new_wl, new_wt, sel_wl, sel_wt;
    logic [CB:0]     cnt_n;
    logic            do_emit, do_start_centre, do_start_index, do_finish;
    logic [WB-1:0]   emit_val;
    logic            out_free;
    logic            move;

    assign b        = byte_reg[7];
    assign fs_sh    = {fs_reg[WB-2:0], b};
    assign fc_inc   = fc_reg + 6'd1;
    assign idx_sum  = {1'b0, lib_reg} + {1'b0, tib_reg};
    assign out_free = !out_valid_reg || m_tready;

    assign status.room       = !pend_valid_reg || out_free;
    assign status.parse_done = (phase_reg == PH_DONE);

    // Table index pair: leading index above, trailing index in the low bits.
    assign idx_src   = (phase_reg == PH_IDX) ? fs_sh[7:0] : 8'd0;
    assign lead_idx  = 4'(idx_src >> tib_reg);
    assign trail_idx = 4'(idx_src & 8'((9'd1 << tib_reg) - 9'd1));
    assign new_wl    = ({1'b0, lead_idx} < 5'(TABLE_ENTRIES))
                       ? lt_reg[lead_idx[TIDX_W-1:0]] : '0;
    assign new_wt    = ({1'b0, trail_idx} < 5'(TABLE_ENTRIES))
                       ? tt_reg[trail_idx[TIDX_W-1:0]] : '0;
    assign cnt_n     = (fs_sh[CB-1:0] == '0) ? 5'd16 : {1'b0, fs_sh[CB-1:0]};

    always_comb begin
        phase_next      = phase_reg;
        lt_next         = lt_reg;
        tt_next         = tt_reg;
        lib_next        = lib_reg;
        tib_next        = tib_reg;
        eq_next         = eq_reg;
        prev_next       = prev_reg;
        wl_next         = wl_reg;
        wt_next         = wt_reg;
        fs_next         = fs_reg;
        fc_next         = fc_reg;
        tpos_next       = tpos_reg;
        tlen_next       = tlen_reg;
        byte_next       = byte_reg;
        do_emit         = 1'b0;
        do_start_centre = 1'b0;
        do_start_index  = 1'b0;
        do_finish       = 1'b0;
        emit_val        = prev_reg;
        sel_wl          = wl_reg;
        sel_wt          = wt_reg;

        if (cmd.load) begin
            byte_next = s_tdata;
            if (s_tuser) begin
                phase_next = PH_EQ;
                fs_next    = '0;
                fc_next    = '0;
                tpos_next  = '0;
                tlen_next  = '0;
            end
        end else if (cmd.step) begin
            byte_next = {byte_reg[6:0], 1'b0};
            case (phase_reg)
                PH_EQ: begin
                    eq_next    = b;
                    phase_next = PH_UPD;
                end
                PH_UPD: begin
                    fs_next    = '0;
                    fc_next    = '0;
                    phase_next = b ? PH_LCNT : PH_CTRL1;
                end
                PH_LCNT, PH_TCNT: begin
                    fs_next = fs_sh;
                    fc_next = fc_inc;
                    if (fc_inc == 6'(CB)) begin
                        // A table load clears every entry before refilling it.
                        if (phase_reg == PH_LCNT) begin
                            lib_next = xfsd_pkg::index_width(cnt_n);
                            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                                lt_next[i] = '0;
                            end
                            phase_next = PH_LENT;
                        end else begin
                            tib_next = xfsd_pkg::index_width(cnt_n);
                            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                                tt_next[i] = '0;
                            end
                            phase_next = PH_TENT;
                        end
                        tlen_next = cnt_n;
                        tpos_next = '0;
                        fs_next   = '0;
                        fc_next   = '0;
                    end
                end
                PH_LENT, PH_TENT: begin
                    fs_next = fs_sh;
                    fc_next = fc_inc;
                    if (fc_inc == 6'(EB)) begin
                        // Entries past the table depth are read and dropped.
                        if (tpos_reg < 5'(TABLE_ENTRIES)) begin
                            if (phase_reg == PH_LENT) begin
                                lt_next[tpos_reg[TIDX_W-1:0]] = fs_sh[EB-1:0];
                            end else begin
                                tt_next[tpos_reg[TIDX_W-1:0]] = fs_sh[EB-1:0];
                            end
                        end
                        tpos_next = tpos_reg + 5'd1;
                        fs_next   = '0;
                        fc_next   = '0;
                        if (tpos_reg + 5'd1 >= tlen_reg) begin
                            phase_next = (phase_reg == PH_LENT) ? PH_TCNT : PH_CTRL1;
                        end
                    end
                end
                PH_CTRL1: begin
                    if (b) begin
                        if (eq_reg) begin
                            do_emit = 1'b1;
                        end else begin
                            do_start_centre = 1'b1;
                        end
                    end else begin
                        phase_next = PH_CTRL2;
                    end
                end
                PH_CTRL2: begin
                    if (eq_reg) begin
                        if (b) begin
                            do_start_centre = 1'b1;
                        end else begin
                            do_start_index = 1'b1;
                        end
                    end else begin
                        if (b) begin
                            do_emit = 1'b1;
                        end else begin
                            do_start_index = 1'b1;
                        end
                    end
                end
                PH_IDX: begin
                    fs_next = fs_sh;
                    fc_next = fc_inc;
                    if (fc_inc >= {2'b00, idx_sum}) begin
                        do_finish = 1'b1;
                    end
                end
                PH_CENTRE: begin
                    fs_next = fs_sh;
                    fc_next = fc_inc;
                    if (fc_inc >= xfsd_pkg::centre_width(wl_reg, wt_reg)) begin
                        do_emit  = 1'b1;
                        emit_val = prev_reg ^ (fs_sh << wt_reg);
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase

            if (do_start_index) begin
                fs_next = '0;
                fc_next = '0;
                if (idx_sum == '0) begin
                    do_finish = 1'b1;
                end else begin
                    phase_next = PH_IDX;
                end
            end
            if (do_finish) begin
                wl_next         = new_wl;
                wt_next         = new_wt;
                sel_wl          = new_wl;
                sel_wt          = new_wt;
                do_start_centre = 1'b1;
            end
            if (do_start_centre) begin
                fs_next = '0;
                fc_next = '0;
                // A window that covers the whole word leaves the value unchanged.
                if (xfsd_pkg::centre_width(sel_wl, sel_wt) == '0) begin
                    do_emit = 1'b1;
                end else begin
                    phase_next = PH_CENTRE;
                end
            end
            if (do_emit) begin
                if (emit_val == xfsd_pkg::END_MARKER) begin
                    phase_next = PH_DONE;
                end else begin
                    prev_next  = emit_val;
                    phase_next = PH_CTRL1;
                end
            end
        end
    end

    // A new result waits in the hold register so that the last one of a byte
    // can be marked once the byte is finished.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_bits_next  = pend_bits_reg;
        pend_end_next   = pend_end_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_bits_next   = out_bits_reg;
        out_end_next    = out_end_reg;
        out_last_next   = out_last_reg;
        move            = (cmd.step && do_emit && pend_valid_reg)
                          || (cmd.flush && pend_valid_reg);
        if (move) begin
            out_valid_next = 1'b1;
            out_bits_next  = pend_bits_reg;
            out_end_next   = pend_end_reg;
            out_last_next  = cmd.flush;
        end
        if (cmd.flush) begin
            pend_valid_next = 1'b0;
        end
        if (cmd.step && do_emit) begin
            pend_valid_next = 1'b1;
            pend_end_next   = (emit_val == xfsd_pkg::END_MARKER);
            pend_bits_next  = pend_end_next ? '0 : emit_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_EQ;
            lib_reg        <= '0;
            tib_reg        <= '0;
            eq_reg         <= 1'b0;
            prev_reg       <= '0;
            wl_reg         <= '0;
            wt_reg         <= '0;
            fs_reg         <= '0;
            fc_reg         <= '0;
            tpos_reg       <= '0;
            tlen_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                lt_reg[i] <= '0;
                tt_reg[i] <= '0;
            end
        end else begin
            phase_reg      <= phase_next;
            lib_reg        <= lib_next;
            tib_reg        <= tib_next;
            eq_reg         <= eq_next;
            prev_reg       <= prev_next;
            wl_reg         <= wl_next;
            wt_reg         <= wt_next;
            fs_reg         <= fs_next;
            fc_reg         <= fc_next;
            tpos_reg       <= tpos_next;
            tlen_reg       <= tlen_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            lt_reg         <= lt_next;
            tt_reg         <= tt_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        pend_bits_reg <= pend_bits_next;
        pend_end_reg  <= pend_end_next;
        out_bits_reg  <= out_bits_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bits_reg;
    assign m_tuser  = out_end_reg;
    assign m_tlast  = out_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        move |-> !out_valid_reg || m_tready)
        else $error("result moved into an output register still waiting");

    a_end_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_end_reg |-> out_bits_reg == '0)
        else $error("end marker result carries nonzero bits");

    a_field_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fc_reg <= 6'd32)
        else $error("field bit count ran past a full word");

    a_end_stops_parse: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && do_emit && emit_val == xfsd_pkg::END_MARKER
        |=> phase_reg == PH_DONE && pend_valid_reg && pend_end_reg)
        else $error("end marker did not stop the parser");

endmodule

### dv/tb_xor_float32_stream_decoder.sv
// Self-checking testbench for xor_float32_stream_decoder: encodes compressed blocks,
// streams them in as bytes and checks every decoded word against a bit-serial predictor.
// Depends on xfsd_pkg and the decoder RTL only.
module tb_xor_float32_stream_decoder;

    typedef enum logic [3:0] {
        HDR_EQ, HDR_UPD, LEAD_CNT, LEAD_ENT, TRAIL_CNT, TRAIL_ENT,
        CODE_A, CODE_B, PAIR_IDX, CENTRE, BLOCK_DONE
    } dec_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stim_byte_t;

    typedef struct packed {
        logic [31:0] value;
        logic        term;
        logic        last;
    } float_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    xor_float32_stream_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and scoreboard storage.
    stim_byte_t  byte_feed[$];
    float_word_t pending_floats[$];
    float_word_t byte_out[$];
    logic        code_bits[$];

    int items_queued  = 0;
    int items_taken   = 0;
    int bytes_parsed  = 0;
    int words_seen    = 0;
    int ends_seen     = 0;
    int input_stalls  = 0;
    int max_burst     = 0;
    int err_count     = 0;
    int snd_idle_pct  = 24;
    int rcv_idle_pct  = 69;
    int hold_request  = 0;
    int hold_left     = 0;
    logic in_fire     = 1'b0;

    // Decoder shadow state.
    logic [4:0]  lead_tab  [16];
    logic [4:0]  trail_tab [16];
    logic [2:0]  lead_ibits, trail_ibits;
    logic        eq_win;
    logic [31:0] prev_val;
    logic [4:0]  win_lead, win_trail;
    dec_phase_t  dec_phase;
    logic [31:0] fshift;
    logic [5:0]  fcount;
    int          tab_pos, tab_len;

    function automatic logic [5:0] centre_span(input logic [4:0] wl, input logic [4:0] wt);
        int total;
        total = int'(wl) + int'(wt);
        if (total >= 32) begin
            return 6'd0;
        end
        return 6'(32 - total);
    endfunction

    function automatic logic [2:0] bits_to_index(input int n);
        int w;
        w = 0;
        while (w < 4 && (1 << w) < n) begin
            w++;
        end
        return 3'(w);
    endfunction

    function automatic void reset_predictor();
        for (int k = 0; k < 16; k++) begin
            lead_tab[k]  = 5'd0;
            trail_tab[k] = 5'd0;
        end
        lead_ibits  = 3'd0;
        trail_ibits = 3'd0;
        eq_win      = 1'b0;
        prev_val    = 32'd0;
        win_lead    = 5'd0;
        win_trail   = 5'd0;
        dec_phase   = HDR_EQ;
        fshift      = 32'd0;
        fcount      = 6'd0;
        tab_pos     = 0;
        tab_len     = 0;
    endfunction

    function automatic void clear_field();
        fshift = 32'd0;
        fcount = 6'd0;
    endfunction

    // A decoded end marker closes the block and leaves the previous value alone.
    function automatic void put_word(input logic [31:0] v);
        float_word_t w;
        w.last = 1'b0;
        if (v == xfsd_pkg::END_MARKER) begin
            w.value   = 32'd0;
            w.term    = 1'b1;
            dec_phase = BLOCK_DONE;
        end else begin
            w.value   = v;
            w.term    = 1'b0;
            prev_val  = v;
            dec_phase = CODE_A;
        end
        byte_out.push_back(w);
    endfunction

    function automatic void begin_centre();
        clear_field();
        if (centre_span(win_lead, win_trail) == 6'd0) begin
            put_word(prev_val);
        end else begin
            dec_phase = CENTRE;
        end
    endfunction

    function automatic void finish_pair();
        logic [31:0] li, ti;
        li = fshift >> trail_ibits;
        ti = fshift & ((32'd1 << trail_ibits) - 32'd1);
        win_lead  = lead_tab[li[3:0]];
        win_trail = trail_tab[ti[3:0]];
        begin_centre();
    endfunction

    function automatic void begin_pair();
        clear_field();
        if (int'(lead_ibits) + int'(trail_ibits) == 0) begin
            finish_pair();
        end else begin
            dec_phase = PAIR_IDX;
        end
    endfunction

    // A table load wipes the whole table, so indexes past the count read zero.
    function automatic void load_count(input logic is_lead);
        int n;
        n = int'(fshift[3:0]);
        if (n == 0) begin
            n = 16;
        end
        for (int k = 0; k < 16; k++) begin
            if (is_lead) begin
                lead_tab[k] = 5'd0;
            end else begin
                trail_tab[k] = 5'd0;
            end
        end
        if (is_lead) begin
            lead_ibits = bits_to_index(n);
        end else begin
            trail_ibits = bits_to_index(n);
        end
        tab_len = n;
        tab_pos = 0;
        clear_field();
    endfunction

    function automatic void take_bit(input logic b);
        case (dec_phase)
            HDR_EQ: begin
                eq_win    = b;
                dec_phase = HDR_UPD;
            end
            HDR_UPD: begin
                clear_field();
                dec_phase = b ? LEAD_CNT : CODE_A;
            end
            LEAD_CNT, TRAIL_CNT: begin
                fshift = {fshift[30:0], b};
                fcount = fcount + 6'd1;
                if (fcount == 6'd4) begin
                    if (dec_phase == LEAD_CNT) begin
                        load_count(1'b1);
                        dec_phase = LEAD_ENT;
                    end else begin
                        load_count(1'b0);
                        dec_phase = TRAIL_ENT;
                    end
                end
            end
            LEAD_ENT, TRAIL_ENT: begin
                fshift = {fshift[30:0], b};
                fcount = fcount + 6'd1;
                if (fcount == 6'd5) begin
                    if (tab_pos < 16) begin
                        if (dec_phase == LEAD_ENT) begin
                            lead_tab[tab_pos] = fshift[4:0];
                        end else begin
                            trail_tab[tab_pos] = fshift[4:0];
                        end
                    end
                    tab_pos++;
                    clear_field();
                    if (tab_pos >= tab_len) begin
                        dec_phase = (dec_phase == LEAD_ENT) ? TRAIL_CNT : CODE_A;
                    end
                end
            end
            CODE_A: begin
                if (!b) begin
                    dec_phase = CODE_B;
                end else if (eq_win) begin
                    put_word(prev_val);
                end else begin
                    begin_centre();
                end
            end
            CODE_B: begin
                if (!b) begin
                    begin_pair();
                end else if (eq_win) begin
                    begin_centre();
                end else begin
                    put_word(prev_val);
                end
            end
            PAIR_IDX: begin
                fshift = {fshift[30:0], b};
                fcount = fcount + 6'd1;
                if (int'(fcount) >= int'(lead_ibits) + int'(trail_ibits)) begin
                    finish_pair();
                end
            end
            CENTRE: begin
                fshift = {fshift[30:0], b};
                fcount = fcount + 6'd1;
                if (fcount >= centre_span(win_lead, win_trail)) begin
                    put_word(prev_val ^ (fshift << win_trail));
                end
            end
            default: begin
                dec_phase = BLOCK_DONE;
            end
        endcase
    endfunction

    // Runs one accepted byte through the shadow decoder and queues its words.
    function automatic void decode_byte(input logic [7:0] d, input logic start);
        int i;
        float_word_t w;
        if (start) begin
            dec_phase = HDR_EQ;
            clear_field();
            tab_pos = 0;
            tab_len = 0;
        end
        if (dec_phase != BLOCK_DONE) begin
            bytes_parsed++;
        end
        byte_out.delete();
        i = 7;
        while (i >= 0 && dec_phase != BLOCK_DONE) begin
            take_bit(d[i]);
            i--;
        end
        if (byte_out.size() > max_burst) begin
            max_burst = byte_out.size();
        end
        for (i = 0; i < byte_out.size(); i++) begin
            w      = byte_out[i];
            w.last = (i == byte_out.size() - 1);
            pending_floats.push_back(w);
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        err_count++;
        $display("[%0t] word %0d: %s got %h, expected %h", $realtime, words_seen,
                 what, got, want);
    endtask

    // Input and output side: a byte or a word is taken on a rising edge with tvalid and tready both high.
    always @(posedge aclk) begin
        float_word_t want;
        in_fire = aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && !s_tready) begin
            input_stalls++;
        end
        if (in_fire) begin
            decode_byte(s_tdata, s_tuser);
            items_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_floats.size() == 0) begin
                flag_mismatch("unexpected word", m_tdata, 32'd0);
            end else begin
                want = pending_floats.pop_front();
                if (m_tdata !== want.value) begin
                    flag_mismatch("float_bits", m_tdata, want.value);
                end
                if (m_tuser !== want.term) begin
                    flag_mismatch("block_end", 32'(m_tuser), 32'(want.term));
                end
                if (m_tlast !== want.last) begin
                    flag_mismatch("last_of_run", 32'(m_tlast), 32'(want.last));
                end
                if (want.term) begin
                    ends_seen++;
                end
            end
            words_seen++;
        end
    end

    always @(negedge aclk) begin
        stim_byte_t nx;
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (byte_feed.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                nx = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nx.data;
                s_tuser  <= nx.start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the stimulus keeps flowing meanwhile.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
        end
    end

    task automatic push_raw(input logic [7:0] d, input logic start);
        stim_byte_t sb;
        sb.data  = d;
        sb.start = start;
        byte_feed.push_back(sb);
        items_queued++;
    endtask

    task automatic push_bits(input logic [31:0] v, input int n);
        int k;
        for (k = n - 1; k >= 0; k--) begin
            code_bits.push_back(v[k]);
        end
    endtask

    task automatic settle();
        while (items_taken != items_queued) begin
            @(posedge aclk);
            #1;
        end
        #1;
    endtask

    task automatic drain();
        while (items_taken != items_queued || pending_floats.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (20) @(posedge aclk);
        #1;
    endtask

    function automatic logic window_fits(input logic [4:0] wl, input logic [4:0] wt,
                                         input logic [31:0] diff);
        logic [5:0]  cw;
        logic [63:0] d;
        cw = centre_span(wl, wt);
        d  = {32'd0, diff};
        if (cw == 6'd0) begin
            return 1'b0;
        end
        return (((d >> wt) >> cw) == 64'd0) && ((diff & ((32'd1 << wt) - 32'd1)) == 32'd0);
    endfunction

    task automatic send_noise(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            push_raw(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    // Builds one compressed block from the decoder's current state and queues it.
    // style 0: any table size, 1: tiny tables and mostly repeats, 2: wide windows.
    // upd_sel 0: keep tables when possible, 1: always load, 2: load at random.
    task automatic encode_block(input int n_vals, input logic ends, input int upd_sel,
                                input int style, input int eq_sel, input int tail);
        logic [4:0]  el [16];
        logic [4:0]  et [16];
        logic [4:0]  fresh [16];
        logic [2:0]  elb, etb;
        logic [31:0] ev, c, diff;
        logic [4:0]  ewl, ewt;
        logic [5:0]  cw;
        logic [7:0]  d;
        logic        eq, upd, zero_ok;
        int          n, k, j, li, ti, kind, r, tsel, v, pick;
        int          fit_l[$];
        int          fit_t[$];
        settle();
        for (k = 0; k < 16; k++) begin
            el[k] = lead_tab[k];
            et[k] = trail_tab[k];
        end
        elb = lead_ibits;
        etb = trail_ibits;
        ev  = prev_val;
        ewl = win_lead;
        ewt = win_trail;
        code_bits.delete();
        eq = (eq_sel == 2) ? 1'($urandom_range(0, 1)) : eq_sel[0];
        // A (0,0) window must stay reachable so the end marker can always be coded.
        zero_ok = 1'b0;
        for (li = 0; li < (1 << elb); li++) begin
            for (ti = 0; ti < (1 << etb); ti++) begin
                if (el[li] == 5'd0 && et[ti] == 5'd0) begin
                    zero_ok = 1'b1;
                end
            end
        end
        upd = !zero_ok || upd_sel == 1 || (upd_sel == 2 && $urandom_range(0, 2) == 0);
        code_bits.push_back(eq);
        code_bits.push_back(upd);
        if (upd) begin
            for (tsel = 0; tsel < 2; tsel++) begin
                case (style)
                    1: n = $urandom_range(1, 3);
                    2: n = $urandom_range(1, 4);
                    default: n = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 16);
                endcase
                for (k = 0; k < 16; k++) begin
                    fresh[k] = 5'd0;
                end
                for (k = 0; k < n; k++) begin
                    fresh[k] = (style == 2) ? 5'($urandom_range(12, 31))
                                            : 5'($urandom_range(0, 31));
                end
                fresh[$urandom_range(0, n - 1)] = 5'd0;
                push_bits(n, 4);
                for (k = 0; k < n; k++) begin
                    push_bits(32'(fresh[k]), 5);
                end
                for (k = 0; k < 16; k++) begin
                    if (tsel == 0) begin
                        el[k] = fresh[k];
                    end else begin
                        et[k] = fresh[k];
                    end
                end
                if (tsel == 0) begin
                    elb = bits_to_index(n);
                end else begin
                    etb = bits_to_index(n);
                end
            end
        end
        for (v = 0; v < n_vals; v++) begin
            r = $urandom_range(0, 9);
            if (style == 1) begin
                kind = (r < 6) ? 0 : ((r < 8) ? 1 : 2);
            end else begin
                kind = r % 3;
            end
            if (kind == 0) begin
                if (!eq) begin
                    code_bits.push_back(1'b0);
                end
                code_bits.push_back(1'b1);
            end else begin
                if (kind == 1) begin
                    if (eq) begin
                        code_bits.push_back(1'b0);
                    end
                    code_bits.push_back(1'b1);
                end else begin
                    push_bits(0, 2);
                    li = $urandom_range(0, (1 << elb) - 1);
                    ti = $urandom_range(0, (1 << etb) - 1);
                    push_bits((li << etb) | ti, int'(elb) + int'(etb));
                    ewl = el[li];
                    ewt = et[ti];
                end
                cw = centre_span(ewl, ewt);
                if (cw != 6'd0) begin
                    c = $urandom();
                    if (cw < 6'd32) begin
                        c = c & ((32'd1 << cw) - 32'd1);
                    end
                    if ((ev ^ (c << ewt)) == xfsd_pkg::END_MARKER) begin
                        c = c ^ 32'd1;
                    end
                    push_bits(c, int'(cw));
                    ev = ev ^ (c << ewt);
                end
            end
        end
        if (ends) begin
            diff = ev ^ xfsd_pkg::END_MARKER;
            if (window_fits(ewl, ewt, diff) && $urandom_range(0, 1) == 1) begin
                if (eq) begin
                    code_bits.push_back(1'b0);
                end
                code_bits.push_back(1'b1);
            end else begin
                for (li = 0; li < (1 << elb); li++) begin
                    for (ti = 0; ti < (1 << etb); ti++) begin
                        if (window_fits(el[li], et[ti], diff)) begin
                            fit_l.push_back(li);
                            fit_t.push_back(ti);
                        end
                    end
                end
                pick = $urandom_range(0, fit_l.size() - 1);
                push_bits(0, 2);
                push_bits((fit_l[pick] << etb) | fit_t[pick], int'(elb) + int'(etb));
                ewl = el[fit_l[pick]];
                ewt = et[fit_t[pick]];
            end
            push_bits(diff >> ewt, int'(centre_span(ewl, ewt)));
        end else begin
            // Cut the block short somewhere inside a code.
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                code_bits.push_back(1'($urandom_range(0, 1)));
            end
        end
        while (code_bits.size() % 8 != 0) begin
            code_bits.push_back(1'($urandom_range(0, 1)));
        end
        for (k = 0; k < code_bits.size(); k += 8) begin
            for (j = 0; j < 8; j++) begin
                d[7 - j] = code_bits[k + j];
            end
            push_raw(d, k == 0);
        end
        for (k = 0; k < tail; k++) begin
            push_raw(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Mostly whole blocks with random content, some cut short, some plain noise.
    task automatic random_traffic(input int goal);
        int stop_at, r;
        settle();
        stop_at = bytes_parsed + goal;
        while (bytes_parsed < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                encode_block($urandom_range(1, 10), 1'b1, 2, $urandom_range(0, 3) % 3, 2,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            end else if (r < 85) begin
                encode_block($urandom_range(1, 6), 1'b0, 2, $urandom_range(0, 2), 2, 0);
            end else begin
                send_noise($urandom_range(1, 4));
            end
            settle();
        end
    endtask

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        reset_predictor();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Before any table load: all-zero and all-one bytes, stopping mid-value.
        push_raw(8'h00, 1'b1);
        push_raw(8'hff, 1'b0);
        push_raw(8'ha5, 1'b0);
        // Tiny tables, so some indexes land past the count; ignored bytes after the end.
        encode_block(5, 1'b1, 1, 1, 1, 1);
        // Tables and previous value carried over from the last block.
        encode_block(3, 1'b1, 0, 0, 0, 0);
        // Wide windows, some summing to 32 or more, with no centre bits.
        encode_block(4, 1'b1, 1, 2, 0, 1);
        // Block that stops partway through a value.
        encode_block(3, 1'b0, 0, 1, 1, 0);
        random_traffic(35);

        drain();
        snd_idle_pct = 69;
        rcv_idle_pct = 24;
        random_traffic(35);

        drain();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // Receiver stalls for a long stretch while a repeat-heavy block keeps arriving.
        hold_request = 150;
        encode_block(24, 1'b1, 0, 1, 1, 0);
        random_traffic(35);

        drain();
        repeat (40) @(posedge aclk);
        $display("Streamed %0d bytes (%0d parsed) and checked %0d words, %0d of them ends.",
                 items_taken, bytes_parsed, words_seen, ends_seen);
        $display("Input back-pressure on %0d cycles; busiest byte produced %0d words.",
                 input_stalls, max_burst);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
design/xfsd_pkg.sv
design/xfsd_ctrl.sv
design/xfsd_dp.sv
design/xor_float32_stream_decoder.sv
dv/tb_xor_float32_stream_decoder.sv
